[hw/rtl/sfgv_pkg.sv]
// shared types and constants of the stroke font glyph vector generator
`default_nettype none

package sfgv_pkg;

    localparam int FONT_WORDS  = 8192;
    localparam int FONT_AW     = $clog2(FONT_WORDS);
    localparam int INDEX_BASE  = 96;
    localparam int MAX_STROKES = 64;
    localparam int CNT_W       = $clog2(MAX_STROKES + 1);

    localparam int APB_AW      = 4;

    localparam logic [1:0] REG_PATH_MODE = 2'd0;
    localparam logic [1:0] REG_ADV_HORIZ = 2'd1;
    localparam logic [1:0] REG_ADV_VERT  = 2'd2;

    localparam logic [15:0] ADV_HORIZ_RESET = 16'd1472;
    localparam logic [15:0] ADV_VERT_RESET  = 16'd2453;

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_DRAW  = 1'b1;

    localparam logic [15:0] CODE_FIRST   = 16'd32;
    localparam logic [15:0] CODE_LAST    = 16'd126;
    localparam logic [15:0] CODE_DEFAULT = 16'd46;

    localparam logic [7:0] OP_PEN_UP = 8'd5;

    typedef enum logic [1:0] {
        PATH_RIGHT = 2'd0,
        PATH_LEFT  = 2'd1,
        PATH_UP    = 2'd2,
        PATH_DOWN  = 2'd3
    } path_t;

    typedef struct packed {
        path_t       path_mode;
        logic [15:0] advance_horizontal;
        logic [15:0] advance_vertical;
    } cfg_t;

    typedef enum logic [2:0] {
        ADDR_HOLD,
        ADDR_START,
        ADDR_END,
        ADDR_STROKE,
        ADDR_NEXT
    } addr_sel_t;

    typedef struct packed {
        logic      mem_write;
        logic      load_item;
        logic      cap_start;
        logic      load_count;
        logic      step;
        logic      advance;
        addr_sel_t addr_sel;
    } cmd_t;

    typedef struct packed {
        logic remain_zero;
        logic out_busy;
    } stat_t;

endpackage

`default_nettype wire

[hw/rtl/sfgv_ifs.sv]
// request and vertex channel interfaces
`default_nettype none

interface sfgv_in_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [12:0] font_address;
    logic [31:0] font_word;
    logic [15:0] char_code;
    logic        segment_start;

    modport source (
        output valid, kind, font_address, font_word, char_code, segment_start,
        input  ready
    );
    modport sink (
        input  valid, kind, font_address, font_word, char_code, segment_start,
        output ready
    );
endinterface

interface sfgv_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] vertex_x;
    logic signed [31:0] vertex_y;
    logic               strip_begin;
    logic               last;

    modport source (
        output valid, vertex_x, vertex_y, strip_begin, last,
        input  ready
    );
    modport sink (
        input  valid, vertex_x, vertex_y, strip_begin, last,
        output ready
    );
endinterface

`default_nettype wire

[hw/rtl/stroke_font_glyph_vector_generator.sv]
// a font load request is taken in the idle state; a draw request runs through these steps:
// an accept state and the index states that read the two index words, then one vertex per cycle
// while the single output register is taken, a state to see the count run out and one to move
// the cell origin; the font memory read sets the one-stroke-per-cycle pace
// reset clears the cell origin, pen and pending vertex and loads register defaults
// font memory has no reset and is loaded through write requests before use
`default_nettype none

module stroke_font_glyph_vector_generator (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [sfgv_pkg::APB_AW-1:0] paddr,
    input  wire logic [31:0]                 pwdata,
    output logic      [31:0]                 prdata,
    output logic                             pready,
    sfgv_in_if.sink                          char_in,
    sfgv_out_if.source                       vertex_out
);

    sfgv_pkg::cfg_t  cfg;
    sfgv_pkg::cmd_t  cmd;
    sfgv_pkg::stat_t stat;

    sfgv_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    sfgv_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (char_in.valid),
        .in_kind  (char_in.kind),
        .in_ready (char_in.ready),
        .cmd      (cmd),
        .stat     (stat)
    );

    sfgv_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .cfg           (cfg),
        .font_address  (char_in.font_address),
        .font_word     (char_in.font_word),
        .char_code     (char_in.char_code),
        .segment_start (char_in.segment_start),
        .out_valid     (vertex_out.valid),
        .out_ready     (vertex_out.ready),
        .vertex_x      (vertex_out.vertex_x),
        .vertex_y      (vertex_out.vertex_y),
        .strip_begin   (vertex_out.strip_begin),
        .last          (vertex_out.last)
    );

endmodule

`default_nettype wire

[hw/rtl/sfgv_regs.sv]
// apb configuration registers
`default_nettype none

module sfgv_regs (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [sfgv_pkg::APB_AW-1:0] paddr,
    input  wire logic [31:0]                pwdata,
    output logic      [31:0]                prdata,
    output logic                            pready,
    output sfgv_pkg::cfg_t                  cfg
);

    sfgv_pkg::cfg_t cfg_reg;
    logic           wr_en;

    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.path_mode          <= sfgv_pkg::PATH_RIGHT;
            cfg_reg.advance_horizontal <= sfgv_pkg::ADV_HORIZ_RESET;
            cfg_reg.advance_vertical   <= sfgv_pkg::ADV_VERT_RESET;
        end
        else if (wr_en)
        begin
            unique case (paddr[3:2])
                sfgv_pkg::REG_PATH_MODE:
                    cfg_reg.path_mode <= sfgv_pkg::path_t'(pwdata[1:0]);
                sfgv_pkg::REG_ADV_HORIZ:
                    cfg_reg.advance_horizontal <= pwdata[15:0];
                sfgv_pkg::REG_ADV_VERT:
                    cfg_reg.advance_vertical <= pwdata[15:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            sfgv_pkg::REG_PATH_MODE: prdata = {30'd0, cfg_reg.path_mode};
            sfgv_pkg::REG_ADV_HORIZ: prdata = {16'd0, cfg_reg.advance_horizontal};
            sfgv_pkg::REG_ADV_VERT:  prdata = {16'd0, cfg_reg.advance_vertical};
            default:                 prdata = 32'd0;
        endcase
    end

endmodule

`default_nettype wire

[hw/rtl/sfgv_ctrl.sv]
// controller state machine for font loads and glyph walks
`default_nettype none

module sfgv_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    input  wire logic            in_kind,
    output logic                 in_ready,
    output sfgv_pkg::cmd_t       cmd,
    input  wire sfgv_pkg::stat_t stat
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_IDX0,
        S_IDX1,
        S_COUNT,
        S_WALK,
        S_ADV
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        in_ready     = 1'b0;
        cmd          = '0;
        cmd.addr_sel = sfgv_pkg::ADDR_HOLD;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (in_kind == sfgv_pkg::KIND_DRAW)
                    begin
                        cmd.load_item = 1'b1;
                        state_next    = S_IDX0;
                    end
                    else
                    begin
                        cmd.mem_write = 1'b1;
                    end
                end
            end
            S_IDX0:
            begin
                cmd.addr_sel = sfgv_pkg::ADDR_START;
                state_next   = S_IDX1;
            end
            S_IDX1:
            begin
                cmd.cap_start = 1'b1;
                cmd.addr_sel  = sfgv_pkg::ADDR_END;
                state_next    = S_COUNT;
            end
            S_COUNT:
            begin
                cmd.load_count = 1'b1;
                cmd.addr_sel   = sfgv_pkg::ADDR_STROKE;
                state_next     = S_WALK;
            end
            S_WALK:
            begin
                if (stat.remain_zero)
                begin
                    state_next = S_ADV;
                end
                else if (!stat.out_busy)
                begin
                    cmd.step     = 1'b1;
                    cmd.addr_sel = sfgv_pkg::ADDR_NEXT;
                end
            end
            S_ADV:
            begin
                cmd.advance = 1'b1;
                state_next  = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

[hw/rtl/sfgv_dp.sv]
// datapath: font memory, pen and cell accumulators, vertex output register
`default_nettype none

module sfgv_dp (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire sfgv_pkg::cmd_t     cmd,
    output sfgv_pkg::stat_t         stat,
    input  wire sfgv_pkg::cfg_t     cfg,
    input  wire logic [12:0]        font_address,
    input  wire logic [31:0]        font_word,
    input  wire logic [15:0]        char_code,
    input  wire logic               segment_start,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic signed [31:0]      vertex_x,
    output logic signed [31:0]      vertex_y,
    output logic                    strip_begin,
    output logic                    last
);

    localparam int AW = sfgv_pkg::FONT_AW;
    localparam int CW = sfgv_pkg::CNT_W;

    // adds or subtracts an unsigned magnitude, clamped to the signed 32-bit range
    function automatic logic [31:0] sat_add(
        input logic [31:0] base,
        input logic        neg,
        input logic [15:0] mag
    );
        logic [32:0] sum;
        logic [31:0] res;
        if (neg)
        begin
            sum = {base[31], base} - {17'd0, mag};
        end
        else
        begin
            sum = {base[31], base} + {17'd0, mag};
        end
        if (sum[32] != sum[31])
        begin
            res = sum[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
        else
        begin
            res = sum[31:0];
        end
        return res;
    endfunction

    logic [31:0]   font_mem [sfgv_pkg::FONT_WORDS];
    logic [31:0]   rdata_reg;
    logic [AW-1:0] addr_reg;
    logic [AW-1:0] addr_next;
    logic [6:0]    code_idx_reg;
    logic [31:0]   start_reg;
    logic [CW-1:0] remain_reg;
    logic          first_reg;
    logic [31:0]   cell_x_reg;
    logic [31:0]   cell_y_reg;
    logic [31:0]   pen_x_reg;
    logic [31:0]   pen_y_reg;
    logic          out_valid_reg;
    logic [31:0]   vx_reg;
    logic [31:0]   vy_reg;
    logic          strip_reg;
    logic          last_reg;

    logic [15:0]   code_mapped;
    logic [15:0]   code_off;
    logic [32:0]   diff;
    logic [CW-1:0] count;
    logic [31:0]   pen_x_step;
    logic [31:0]   pen_y_step;

    always_comb
    begin
        if (char_code < sfgv_pkg::CODE_FIRST || char_code > sfgv_pkg::CODE_LAST)
        begin
            code_mapped = sfgv_pkg::CODE_DEFAULT;
        end
        else
        begin
            code_mapped = char_code;
        end
        code_off = code_mapped - sfgv_pkg::CODE_FIRST;
    end

    always_comb
    begin
        unique case (cmd.addr_sel)
            sfgv_pkg::ADDR_HOLD:   addr_next = addr_reg;
            sfgv_pkg::ADDR_START:  addr_next = AW'(code_idx_reg);
            sfgv_pkg::ADDR_END:    addr_next = AW'(code_idx_reg) + AW'(1);
            sfgv_pkg::ADDR_STROKE: addr_next = start_reg[AW-1:0]
                                             + AW'(sfgv_pkg::INDEX_BASE - 1);
            sfgv_pkg::ADDR_NEXT:   addr_next = addr_reg + AW'(1);
            default:               addr_next = addr_reg;
        endcase
    end

    // stroke count from the end index in the read register
    always_comb
    begin
        diff = {rdata_reg[31], rdata_reg} - {start_reg[31], start_reg};
        if (diff[32])
        begin
            count = '0;
        end
        else if (diff[31:0] > 32'(sfgv_pkg::MAX_STROKES))
        begin
            count = CW'(sfgv_pkg::MAX_STROKES);
        end
        else
        begin
            count = diff[CW-1:0];
        end
    end

    assign pen_x_step = sat_add(pen_x_reg, rdata_reg[23], {1'b0, rdata_reg[22:12], 4'd0});
    assign pen_y_step = sat_add(pen_y_reg, rdata_reg[11], {1'b0, rdata_reg[10:0], 4'd0});

    always_ff @(posedge clk)
    begin
        if (cmd.mem_write)
        begin
            font_mem[font_address[AW-1:0]] <= font_word;
        end
        rdata_reg <= font_mem[addr_next];
    end

    always_ff @(posedge clk)
    begin
        addr_reg <= addr_next;
        if (cmd.load_item)
        begin
            code_idx_reg <= code_off[6:0];
        end
        if (cmd.cap_start)
        begin
            start_reg <= rdata_reg;
        end
        if (cmd.step)
        begin
            vx_reg    <= pen_x_step;
            vy_reg    <= pen_y_step;
            strip_reg <= first_reg || (rdata_reg[31:24] == sfgv_pkg::OP_PEN_UP);
            last_reg  <= (remain_reg == CW'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            remain_reg    <= '0;
            first_reg     <= 1'b0;
            cell_x_reg    <= '0;
            cell_y_reg    <= '0;
            pen_x_reg     <= '0;
            pen_y_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load_item)
            begin
                first_reg <= 1'b1;
                if (segment_start)
                begin
                    cell_x_reg <= '0;
                    cell_y_reg <= '0;
                    pen_x_reg  <= '0;
                    pen_y_reg  <= '0;
                end
                else
                begin
                    pen_x_reg <= cell_x_reg;
                    pen_y_reg <= cell_y_reg;
                end
            end
            if (cmd.load_count)
            begin
                remain_reg <= count;
            end
            if (cmd.step)
            begin
                pen_x_reg     <= pen_x_step;
                pen_y_reg     <= pen_y_step;
                remain_reg    <= remain_reg - CW'(1);
                first_reg     <= 1'b0;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cmd.advance)
            begin
                unique case (cfg.path_mode)
                    sfgv_pkg::PATH_RIGHT:
                        cell_x_reg <= sat_add(cell_x_reg, 1'b0, cfg.advance_horizontal);
                    sfgv_pkg::PATH_LEFT:
                        cell_x_reg <= sat_add(cell_x_reg, 1'b1, cfg.advance_horizontal);
                    sfgv_pkg::PATH_UP:
                        cell_y_reg <= sat_add(cell_y_reg, 1'b0, cfg.advance_vertical);
                    sfgv_pkg::PATH_DOWN:
                        cell_y_reg <= sat_add(cell_y_reg, 1'b1, cfg.advance_vertical);
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    assign stat.remain_zero = (remain_reg == '0);
    assign stat.out_busy    = out_valid_reg && !out_ready;

    assign out_valid   = out_valid_reg;
    assign vertex_x    = vx_reg;
    assign vertex_y    = vy_reg;
    assign strip_begin = strip_reg;
    assign last        = last_reg;

endmodule

`default_nettype wire

[hw/rtl/sfgv_checker.sv]
// port-level checks of the glyph vector generator and their binding
`default_nettype none

module sfgv_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic        in_kind,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [31:0] out_x,
    input wire logic [31:0] out_y
);

    // a font load leaves the block ready for the next request
    a_write_keeps_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && in_kind == sfgv_pkg::KIND_WRITE) |=> in_ready)
        else $error("ready dropped after font load request");

    // a draw request blocks new requests while its glyph is walked
    a_draw_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && in_kind == sfgv_pkg::KIND_DRAW) |=> !in_ready)
        else $error("request taken during glyph walk");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid)
        else $error("vertex dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> ($stable(out_x) && $stable(out_y)))
        else $error("vertex changed while stalled");

endmodule

bind stroke_font_glyph_vector_generator sfgv_checker u_sfgv_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (char_in.valid),
    .in_ready  (char_in.ready),
    .in_kind   (char_in.kind),
    .out_valid (vertex_out.valid),
    .out_ready (vertex_out.ready),
    .out_x     (vertex_out.vertex_x),
    .out_y     (vertex_out.vertex_y)
);

`default_nettype wire

[tb/sv/testbench.sv]
// self-checking testbench of the stroke font glyph vector generator with a built-in vertex predictor
module testbench;
    import sfgv_pkg::*;

    localparam int STALL_LIMIT  = 3000;
    localparam int HOLD_CYCLES  = 300;
    localparam int RANDOM_ITEMS = 110;
    localparam int SETTLE       = 12;
    localparam int GLYPH_SCRATCH = 2001;
    localparam int POOL_STROKES = 96;
    localparam int POOL_STARTS  = POOL_STROKES - MAX_STROKES + 1;

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic               strip_begin;
        logic               last;
    } vertex_t;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;

    sfgv_in_if  char_ch ();
    sfgv_out_if vertex_ch ();

    stroke_font_glyph_vector_generator i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .char_in    (char_ch),
        .vertex_out (vertex_ch)
    );

    always #1 clk = ~clk;

    logic [31:0]        font_img [0:FONT_WORDS-1];
    bit                 font_known [0:FONT_WORDS-1];
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    path_t              cfg_path;
    logic [15:0]        cfg_adv_h;
    logic [15:0]        cfg_adv_v;
    vertex_t            expected_vertices [$];
    int                 errors = 0;
    bit                 in_idle_on = 1'b1;
    bit                 out_idle_on = 1'b1;
    bit                 hold_pending = 1'b0;

    function automatic logic signed [31:0] clamp32(longint v);
        if (v > longint'(32'sh7FFF_FFFF))
        begin
            return 32'sh7FFF_FFFF;
        end
        if (v < -longint'(64'sh8000_0000))
        begin
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    function automatic longint sm12_value(logic [11:0] f);
        return f[11] ? -longint'(f[10:0]) : longint'(f[10:0]);
    endfunction

    function automatic void glyph_span(input logic [15:0] code, output longint first,
                                       output longint count);
        logic [15:0] c;
        longint      stop;
        c = code;
        if (c < CODE_FIRST || c > CODE_LAST)
        begin
            c = CODE_DEFAULT;
        end
        first = longint'($signed(font_img[c - CODE_FIRST]));
        stop  = longint'($signed(font_img[c - CODE_FIRST + 16'd1]));
        count = stop - first;
        if (count < 0)
        begin
            count = 0;
        end
        if (count > MAX_STROKES)
        begin
            count = MAX_STROKES;
        end
    endfunction

    function automatic int stroke_address(longint first, longint k);
        return int'((first + k + INDEX_BASE - 1) & longint'(FONT_WORDS - 1));
    endfunction

    function automatic logic [31:0] random_stroke();
        logic [31:0] w;
        w = $urandom;
        if ($urandom_range(0, 2) == 0)
        begin
            w[31:24] = OP_PEN_UP;
        end
        return w;
    endfunction

    task automatic predict_glyph(logic [15:0] code, logic seg);
        longint             first;
        longint             count;
        logic [31:0]        w;
        logic signed [31:0] px;
        logic signed [31:0] py;
        vertex_t            v;
        if (seg)
        begin
            origin_x = 0;
            origin_y = 0;
        end
        px = origin_x;
        py = origin_y;
        glyph_span(code, first, count);
        for (longint k = 0; k < count; k++)
        begin
            w  = font_img[stroke_address(first, k)];
            px = clamp32(longint'(px) + sm12_value(w[23:12]) * 16);
            py = clamp32(longint'(py) + sm12_value(w[11:0]) * 16);
            v.x = px;
            v.y = py;
            v.strip_begin = (k == 0) || (w[31:24] == OP_PEN_UP);
            v.last = (k == count - 1);
            expected_vertices.push_back(v);
        end
        case (cfg_path)
            PATH_LEFT:  origin_x = clamp32(longint'(origin_x) - longint'(cfg_adv_h));
            PATH_UP:    origin_y = clamp32(longint'(origin_y) + longint'(cfg_adv_v));
            PATH_DOWN:  origin_y = clamp32(longint'(origin_y) - longint'(cfg_adv_v));
            default:    origin_x = clamp32(longint'(origin_x) + longint'(cfg_adv_h));
        endcase
    endtask

    // one request on the character channel, predicted when accepted
    task automatic send_item(logic kind, logic [12:0] addr, logic [31:0] word,
                             logic [15:0] code, logic seg);
        @(negedge clk);
        if (in_idle_on)
        begin
            while ($urandom_range(0, 99) < 26)
            begin
                char_ch.valid <= 1'b0;
                @(negedge clk);
            end
        end
        char_ch.valid         <= 1'b1;
        char_ch.kind          <= kind;
        char_ch.font_address  <= addr;
        char_ch.font_word     <= word;
        char_ch.char_code     <= code;
        char_ch.segment_start <= seg;
        do
            @(posedge clk);
        while (char_ch.ready !== 1'b1);
        if (kind == KIND_WRITE)
        begin
            font_img[addr]   = word;
            font_known[addr] = 1'b1;
        end
        else
        begin
            predict_glyph(code, seg);
        end
    endtask

    task automatic write_font(int addr, logic [31:0] word);
        send_item(KIND_WRITE, 13'(addr), word, 16'($urandom), 1'($urandom));
    endtask

    task automatic set_glyph(logic [15:0] code, logic [31:0] first, logic [31:0] stop);
        write_font(int'(code - CODE_FIRST), first);
        write_font(int'(code - CODE_FIRST) + 1, stop);
    endtask

    task automatic put_stroke(int index, logic [31:0] word);
        write_font(INDEX_BASE + index - 1, word);
    endtask

    // stroke words a glyph would read and that were never loaded get random content first
    task automatic draw_char(logic [15:0] code, logic seg);
        longint first;
        longint count;
        int     addr;
        glyph_span(code, first, count);
        for (longint k = 0; k < count; k++)
        begin
            addr = stroke_address(first, k);
            if (!font_known[addr])
            begin
                write_font(addr, random_stroke());
            end
        end
        send_item(KIND_DRAW, 13'($urandom), $urandom, code, seg);
    endtask

    task automatic quiesce();
        @(negedge clk);
        char_ch.valid <= 1'b0;
        while (expected_vertices.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_register(logic [1:0] idx, logic [31:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        case (idx)
            REG_PATH_MODE: cfg_path  = path_t'(value[1:0]);
            REG_ADV_HORIZ: cfg_adv_h = value[15:0];
            REG_ADV_VERT:  cfg_adv_v = value[15:0];
            default: ;
        endcase
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic configure(path_t path, logic [15:0] adv_h, logic [15:0] adv_v);
        quiesce();
        write_register(REG_PATH_MODE, {$urandom_range(0, 1) ? 30'($urandom) : 30'd0, path});
        write_register(REG_ADV_HORIZ, {$urandom_range(0, 1) ? 16'($urandom) : 16'd0, adv_h});
        write_register(REG_ADV_VERT, {$urandom_range(0, 1) ? 16'($urandom) : 16'd0, adv_v});
    endtask

    function automatic logic [15:0] pick_advance();
        case ($urandom_range(0, 3))
            0:       return 16'd0;
            1:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // index table over one shared pool of stroke words, glyphs overlap, space left empty
    task automatic test_font_load();
        write_font(0, 32'd1);
        write_font(1, 32'd1);
        for (int i = 2; i < 96; i++)
        begin
            write_font(i, 32'($urandom_range(1, POOL_STARTS)));
        end
        for (int i = 1; i <= POOL_STROKES; i++)
        begin
            put_stroke(i, random_stroke());
        end
    endtask

    task automatic test_glyph_cases();
        put_stroke(GLYPH_SCRATCH + 0, {OP_PEN_UP, 12'h7FF, 12'h7FF});
        put_stroke(GLYPH_SCRATCH + 1, {8'h00, 12'hFFF, 12'hFFF});
        put_stroke(GLYPH_SCRATCH + 2, {8'h00, 12'h800, 12'h800});
        put_stroke(GLYPH_SCRATCH + 3, {8'hFF, 12'h001, 12'h801});
        put_stroke(GLYPH_SCRATCH + 4, {OP_PEN_UP, 12'h7FF, 12'h000});
        put_stroke(GLYPH_SCRATCH + 5, {8'h04, 12'h000, 12'hFFF});
        set_glyph("A", GLYPH_SCRATCH, GLYPH_SCRATCH + 6);
        draw_char("A", 1'b1);
        draw_char(CODE_FIRST, 1'b0);
        draw_char(CODE_LAST, 1'b0);
        draw_char(16'd31, 1'b0);
        draw_char(16'd127, 1'b0);
        draw_char(16'd0, 1'b0);
        draw_char(16'hFFFF, 1'b0);
        draw_char(CODE_DEFAULT, 1'b1);
        draw_char("A", 1'b0);
    endtask

    // odd index words, all on the last code
    task automatic test_index_cases();
        set_glyph(CODE_LAST, 32'd1, 32'd101);
        draw_char(CODE_LAST, 1'b0);
        set_glyph(CODE_LAST, -32'sd100, -32'sd96);
        draw_char(CODE_LAST, 1'b0);
        set_glyph(CODE_LAST, 32'h8000_0000, 32'h8000_0003);
        draw_char(CODE_LAST, 1'b0);
        set_glyph(CODE_LAST, 32'h8000_0000, 32'h7FFF_FFFF);
        draw_char(CODE_LAST, 1'b0);
        set_glyph(CODE_LAST, 32'h7FFF_FFFF, 32'h8000_0000);
        draw_char(CODE_LAST, 1'b0);
        set_glyph(CODE_LAST, 32'd8100, 32'd8103);
        draw_char(CODE_LAST, 1'b0);
        set_glyph(CODE_LAST, 32'd10, 32'd10);
        draw_char(CODE_LAST, 1'b0);
        set_glyph(CODE_LAST, GLYPH_SCRATCH + 30, GLYPH_SCRATCH + 35);
        draw_char(CODE_LAST, 1'b0);
    endtask

    task automatic test_registers();
        configure(PATH_LEFT, 16'd0, 16'h1234);
        for (int i = 0; i < 3; i++)
        begin
            draw_char(16'($urandom_range(33, 126)), i == 0);
        end
        configure(PATH_UP, 16'h0F0F, 16'hFFFF);
        for (int i = 0; i < 3; i++)
        begin
            draw_char(16'($urandom_range(33, 126)), 1'b0);
        end
        configure(PATH_DOWN, 16'hFFFF, 16'd0);
        for (int i = 0; i < 3; i++)
        begin
            draw_char(16'($urandom_range(33, 126)), 1'b0);
        end
        configure(PATH_RIGHT, ADV_HORIZ_RESET, ADV_VERT_RESET);
        for (int i = 0; i < 3; i++)
        begin
            draw_char(16'($urandom_range(33, 126)), 1'b0);
        end
    endtask

    // output held off while draws keep coming, then the sender waits for the backlog
    task automatic test_backpressure();
        hold_pending = 1'b1;
        for (int i = 0; i < 12; i++)
        begin
            draw_char(i[0] ? "A" : 16'($urandom_range(33, 126)), 1'b0);
        end
        quiesce();
    endtask

    task automatic test_random();
        int          r;
        logic [15:0] code;
        logic [31:0] idx;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 80 == 40)
            begin
                configure(path_t'($urandom_range(0, 3)), pick_advance(), pick_advance());
            end
            in_idle_on  = !(n >= 30 && n < 80);
            out_idle_on = in_idle_on;
            r = $urandom_range(0, 99);
            if (r < 70)
            begin
                case ($urandom_range(0, 9))
                    0:       code = 16'($urandom);
                    1:       code = $urandom_range(0, 1) ? 16'($urandom_range(0, 31))
                                                         : 16'($urandom_range(127, 255));
                    default: code = 16'($urandom_range(32, 126));
                endcase
                draw_char(code, $urandom_range(0, 9) == 0);
            end
            else if (r < 85)
            begin
                write_font(INDEX_BASE + $urandom_range(0, POOL_STROKES - 1), random_stroke());
            end
            else if (r < 95)
            begin
                idx = $urandom_range(1, POOL_STARTS);
                if ($urandom_range(0, 3) == 0)
                begin
                    idx = idx + 32'(8192 * ($urandom_range(0, 200) - 100));
                end
                write_font($urandom_range(1, 95), idx);
            end
            else
            begin
                write_font($urandom_range(INDEX_BASE, FONT_WORDS - 1), $urandom);
            end
        end
        in_idle_on  = 1'b1;
        out_idle_on = 1'b1;
    endtask

    // vertex receiver with random stalls and the long hold-off
    initial
    begin
        vertex_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_pending)
            begin
                hold_pending = 1'b0;
                vertex_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            else
            begin
                vertex_ch.ready <= (!out_idle_on || $urandom_range(0, 99) >= 26);
            end
        end
    end

    always @(posedge clk)
    begin : check_vertex
        vertex_t want;
        if (rst_n && vertex_ch.valid === 1'b1 && vertex_ch.ready === 1'b1)
        begin
            if (expected_vertices.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected vertex x=%0d y=%0d strip_begin=%0b last=%0b",
                         $time, vertex_ch.vertex_x, vertex_ch.vertex_y,
                         vertex_ch.strip_begin, vertex_ch.last);
            end
            else
            begin
                want = expected_vertices.pop_front();
                if (vertex_ch.vertex_x !== want.x)
                begin
                    errors++;
                    $display("%0t: vertex_x expected %0d, got %0d",
                             $time, want.x, vertex_ch.vertex_x);
                end
                if (vertex_ch.vertex_y !== want.y)
                begin
                    errors++;
                    $display("%0t: vertex_y expected %0d, got %0d",
                             $time, want.y, vertex_ch.vertex_y);
                end
                if (vertex_ch.strip_begin !== want.strip_begin)
                begin
                    errors++;
                    $display("%0t: strip_begin expected %0b, got %0b",
                             $time, want.strip_begin, vertex_ch.strip_begin);
                end
                if (vertex_ch.last !== want.last)
                begin
                    errors++;
                    $display("%0t: last expected %0b, got %0b",
                             $time, want.last, vertex_ch.last);
                end
            end
        end
    end

    // ends the run after too many cycles without any transfer
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((char_ch.valid === 1'b1 && char_ch.ready === 1'b1) ||
                (vertex_ch.valid === 1'b1 && vertex_ch.ready === 1'b1) || psel)
            begin
                quiet = 0;
            end
            else
            begin
                quiet++;
            end
        end
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        rst_n                 = 1'b0;
        psel                  = 1'b0;
        penable               = 1'b0;
        pwrite                = 1'b0;
        paddr                 = '0;
        pwdata                = '0;
        char_ch.valid         = 1'b0;
        char_ch.kind          = KIND_WRITE;
        char_ch.font_address  = '0;
        char_ch.font_word     = '0;
        char_ch.char_code     = '0;
        char_ch.segment_start = 1'b0;
        origin_x              = 0;
        origin_y              = 0;
        cfg_path              = PATH_RIGHT;
        cfg_adv_h             = ADV_HORIZ_RESET;
        cfg_adv_v             = ADV_VERT_RESET;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_font_load();
        test_glyph_cases();
        test_index_cases();
        test_registers();
        test_backpressure();
        test_random();

        quiesce();
        repeat (20) @(posedge clk);
        if (errors == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
